### hdl/icsum_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the streaming Internet checksum block.
// Has no dependencies; used by every module under hdl.
package icsum_pkg;

    localparam int DATA_W          = 8;
    localparam int MODE_W          = 2;
    localparam int SUM_W           = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [SUM_W-1:0] SUM_MASK  = 16'hFFFF;
    localparam logic [SUM_W-1:0] HIGH_MASK = 16'hFF00;

    localparam logic [SUM_W-1:0] PROTO_UDP = 16'd17;
    localparam logic [SUM_W-1:0] PROTO_TCP = 16'd6;

    localparam logic [SUM_W-1:0] PSEUDO_HDR_BYTES = 16'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_IP  = 2'd0,
        MODE_UDP = 2'd1,
        MODE_TCP = 2'd2
    } t_mode;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
        logic [MODE_W-1:0] mode;
    } t_item;

endpackage

### hdl/icsum_in_stage.sv
`timescale 1ns / 1ps
// Input register for the checksum block: holds one accepted byte transaction.
// Depends on icsum_pkg for the item type.
module icsum_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  icsum_pkg::t_item i_item,
    output logic            o_valid,
    output icsum_pkg::t_item o_item,
    input  logic            i_take
);
    import icsum_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hdl/icsum_core.sv
`timescale 1ns / 1ps
// Checksum state and result register: folds each byte into the running sum
// and produces the final checksum on the last byte. Depends on icsum_pkg.
module icsum_core #(
    parameter int COUNT_WIDTH = icsum_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  icsum_pkg::t_item            i_item,
    output logic                        o_take,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [icsum_pkg::SUM_W-1:0] o_checksum
);
    import icsum_pkg::*;

    logic [SUM_W-1:0]       r_sum;
    logic [DATA_W-1:0]      r_held;
    logic                   r_odd;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_out_valid;
    logic [SUM_W-1:0]       r_checksum;

    logic [SUM_W-1:0]       n_sum;
    logic [DATA_W-1:0]      n_held;
    logic                   n_odd;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   n_out_valid;

    logic [COUNT_WIDTH-1:0] len_term;
    logic [31:0]            len_wide;
    logic [SUM_W-1:0]       word;
    logic [SUM_W-1:0]       word_term;
    logic [SUM_W-1:0]       proto_term;
    logic [SUM_W-1:0]       len_lo;
    logic [SUM_W-1:0]       len_hi;
    logic                   pseudo;
    logic [SUM_W+2:0]       total;
    logic [SUM_W:0]         fold1;
    logic [SUM_W-1:0]       fold2;
    logic                   load_out;

    assign o_take   = i_valid && (!i_item.last_byte || !r_out_valid || i_out_ready);
    assign load_out = o_take && i_item.last_byte;

    assign n_count  = r_count + COUNT_WIDTH'(1);
    assign len_term = n_count - COUNT_WIDTH'(PSEUDO_HDR_BYTES);
    assign len_wide = 32'(len_term);

    // A pending high byte pairs with this byte; otherwise this byte is the
    // high half, padded with zero when it ends the region.
    assign word = r_odd ? {r_held, i_item.data_byte}
                        : ({i_item.data_byte, r_held} & HIGH_MASK);
    assign word_term = (r_odd || i_item.last_byte) ? word : '0;

    always_comb begin
        proto_term = '0;
        pseudo     = 1'b0;
        if (i_item.last_byte) begin
            case (t_mode'(i_item.mode))
                MODE_UDP: begin
                    proto_term = PROTO_UDP;
                    pseudo     = 1'b1;
                end
                MODE_TCP: begin
                    proto_term = PROTO_TCP;
                    pseudo     = 1'b1;
                end
                default: begin
                    proto_term = '0;
                    pseudo     = 1'b0;
                end
            endcase
        end
    end

    assign len_lo = pseudo ? len_wide[15:0]  : '0;
    assign len_hi = pseudo ? len_wide[31:16] : '0;

    assign total = (SUM_W+3)'(r_sum) + (SUM_W+3)'(word_term) + (SUM_W+3)'(proto_term)
                 + (SUM_W+3)'(len_lo) + (SUM_W+3)'(len_hi);
    assign fold1 = (SUM_W+1)'(total[SUM_W-1:0]) + (SUM_W+1)'(total[SUM_W+2:SUM_W]);
    assign fold2 = fold1[SUM_W-1:0] + SUM_W'(fold1[SUM_W]);

    always_comb begin
        n_sum  = r_sum;
        n_held = r_held;
        n_odd  = r_odd;
        if (o_take) begin
            if (i_item.last_byte) begin
                n_sum  = '0;
                n_held = '0;
                n_odd  = 1'b0;
            end else if (r_odd) begin
                n_sum  = fold2;
                n_held = '0;
                n_odd  = 1'b0;
            end else begin
                n_held = i_item.data_byte;
                n_odd  = 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_held      <= '0;
            r_odd       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_held      <= n_held;
            r_odd       <= n_odd;
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_count <= i_item.last_byte ? '0 : n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_checksum <= fold2 ^ SUM_MASK;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_checksum  = r_checksum;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_count == '0) && !r_odd && (r_sum == '0))
        else $error("state not cleared after the last byte");

    a_held_zero_when_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_odd |-> (r_held == '0))
        else $error("held byte not zero without a pending word");

    a_count_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[0] == r_odd)
        else $error("byte count parity disagrees with word position");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

### hdl/internet_checksum_stream.sv
`timescale 1ns / 1ps
// Top level of the streaming Internet checksum block.
// Depends on icsum_pkg, icsum_in_stage and icsum_core.
//
// The block takes one byte per clock cycle, a sustained rate of one
// transaction per cycle with no gaps between regions, while the slave side
// does not stall. Each byte passes through an input register and is folded
// into the running ones' complement sum by a single five-term add with
// end-around carry, which sets the cycle. The core loads a region's checksum
// into the result register as it takes the last byte, and the next region's
// first byte may be accepted in that same cycle. The slave side stalls only
// when a finished checksum still waits in the result register and the byte
// in the input register is itself the last byte of the next region.
module internet_checksum_stream #(
    parameter int COUNT_WIDTH = icsum_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [icsum_pkg::DATA_W-1:0] s_axis_tdata,   // data_byte
    input  logic                         s_axis_tlast,   // last_byte
    input  logic [icsum_pkg::MODE_W-1:0] s_axis_tuser,   // mode
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [icsum_pkg::SUM_W-1:0]  m_axis_tdata    // checksum
);
    import icsum_pkg::*;

    t_item in_item;
    t_item stage_item;
    logic  stage_valid;
    logic  stage_take;

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.last_byte = s_axis_tlast;
    assign in_item.mode      = s_axis_tuser;

    icsum_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (stage_take)
    );

    icsum_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_take      (stage_take),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_checksum  (m_axis_tdata)
    );

endmodule
